>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lct_pkg.sv
// ----------------------------------------------------------------------------
// lct_pkg
// Types, codes and constants shared by the candidate table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lct_pkg;

  // Field widths.
  localparam int OP_W    = 2;
  localparam int KEY_W   = 64;
  localparam int STAMP_W = 32;
  localparam int CTR_W   = 32;
  localparam int STALE_W = 20;
  localparam int ST_W    = 2;
  localparam int SLOT_W  = 5;
  localparam int NUM_W   = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_BIND   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_SELECT = 2'd3;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_NONE   = 2'd0;
  localparam logic [ST_W-1:0] ST_HIT    = 2'd1;
  localparam logic [ST_W-1:0] ST_INSERT = 2'd2;
  localparam logic [ST_W-1:0] ST_EVICT  = 2'd3;

  // Staleness threshold after reset, in frames.
  localparam logic [STALE_W-1:0] STALE_RESET = 20'd600;

  // One stored table entry.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stamp;
    logic [CTR_W-1:0]   binds;
    logic [CTR_W-1:0]   clears;
  } lct_entry_t;

  // One result item.
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0] evicted_key;
    logic             selected_dropped;
    logic [CTR_W-1:0] bind_count;
    logic [CTR_W-1:0] clear_count;
    logic [CTR_W-1:0] version;
    logic [NUM_W-1:0] entry_count;
    logic             selected_fresh;
  } lct_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // latch a new item and begin the table scan
    logic commit;  // update the table and load the result register
  } lct_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // the last entry is being examined this cycle
    logic out_free;   // the result register can take a new result
  } lct_stat_t;

  // Saturating increment of a 32-bit counter.
  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/lct_in_if.sv
// ----------------------------------------------------------------------------
// lct_in_if
// Event channel into the candidate table: operation and key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lct_in_if;
  import lct_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [KEY_W-1:0] key;

  modport source (output valid, output operation, output key, input ready);
  modport sink (input valid, input operation, input key, output ready);
endinterface

`default_nettype wire

>>> rtl/lct_out_if.sv
// ----------------------------------------------------------------------------
// lct_out_if
// Result channel out of the candidate table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lct_out_if;
  import lct_pkg::*;

  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [SLOT_W-1:0] slot;
  logic [KEY_W-1:0]  evicted_key;
  logic              selected_dropped;
  logic [CTR_W-1:0]  bind_count;
  logic [CTR_W-1:0]  clear_count;
  logic [CTR_W-1:0]  version;
  logic [NUM_W-1:0]  entry_count;
  logic              selected_fresh;

  modport source (
    output valid, output status, output slot, output evicted_key,
    output selected_dropped, output bind_count, output clear_count,
    output version, output entry_count, output selected_fresh,
    input ready
  );
  modport sink (
    input valid, input status, input slot, input evicted_key,
    input selected_dropped, input bind_count, input clear_count,
    input version, input entry_count, input selected_fresh,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/lct_datapath.sv
// ----------------------------------------------------------------------------
// lct_datapath
// Entry memory, scan trackers, table update and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lct_datapath #(
  parameter int ENTRIES = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lct_pkg::lct_cmd_t          cmd,
  output lct_pkg::lct_stat_t         stat,
  input  logic [lct_pkg::OP_W-1:0]    in_operation,
  input  logic [lct_pkg::KEY_W-1:0]   in_key,
  input  logic                       cfg_we,
  input  logic [lct_pkg::STALE_W-1:0] cfg_wdata,
  output lct_pkg::lct_res_t          res,
  output logic                       res_valid,
  input  logic                       res_ready
);
  import lct_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // Item, configuration and global state.
  logic [OP_W-1:0]    op_r;
  logic [KEY_W-1:0]   key_r;
  logic [STALE_W-1:0] stale_r;
  logic [STAMP_W-1:0] frame_r;
  logic [KEY_W-1:0]   sel_r;
  logic [CTR_W-1:0]   version_r;
  logic [CNT_W-1:0]   count_r;
  logic [ENTRIES-1:0] valid_r;

  // Entry memory and its scan read stage.
  lct_entry_t       mem [ENTRIES];
  logic [IDX_W-1:0] addr_r;
  logic             issue_r;
  logic             rd_v_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_valid_r;
  lct_entry_t       rd_q_r;

  // Scan trackers.
  logic               hit_r;
  logic [IDX_W-1:0]   hit_slot_r;
  logic [CTR_W-1:0]   hit_binds_r;
  logic [CTR_W-1:0]   hit_clears_r;
  logic               free_r;
  logic [IDX_W-1:0]   free_slot_r;
  logic               lru_any_r;
  logic [IDX_W-1:0]   lru_slot_r;
  logic [KEY_W-1:0]   lru_key_r;
  logic [STAMP_W-1:0] lru_stamp_r;
  logic               selhit_r;
  logic [STAMP_W-1:0] sel_stamp_r;

  // Result register.
  lct_res_t res_r;
  logic     res_valid_r;

  // Comparisons on the entry under examination.
  logic live;
  logic key_eq;
  logic sel_eq;
  logic lru_better;

  // Commit results.
  logic               is_event;
  logic [IDX_W-1:0]   wslot;
  logic [CTR_W-1:0]   binds0;
  logic [CTR_W-1:0]   clears0;
  logic [CTR_W-1:0]   binds_nxt;
  logic [CTR_W-1:0]   clears_nxt;
  logic [ST_W-1:0]    status_nxt;
  logic [KEY_W-1:0]   evicted_nxt;
  logic               dropped_nxt;
  logic [KEY_W-1:0]   sel_nxt;
  logic [CTR_W-1:0]   version_nxt;
  logic [CNT_W-1:0]   count_nxt;
  logic [STAMP_W-1:0] fresh_stamp;
  logic               fresh_found;
  logic [STAMP_W-1:0] age;
  logic               fresh_nxt;
  logic               write_en;
  logic [IDX_W+SLOT_W-1:0] slot_wide;
  logic [CNT_W+NUM_W-1:0]  count_wide;
  lct_res_t           res_nxt;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stale_r <= STALE_RESET;
    end else if (cfg_we) begin
      stale_r <= cfg_wdata;
    end
  end

  // Item capture; a tick advances the frame, a select sets the selection.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= in_operation;
      key_r <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= '0;
    end else if (cmd.start && in_operation == OP_TICK) begin
      frame_r <= frame_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= '0;
    end else if (cmd.start && in_operation == OP_SELECT) begin
      sel_r <= in_key;
    end else if (cmd.commit) begin
      sel_r <= sel_nxt;
    end
  end

  // Scan address sequencing: one read issued per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      rd_v_r  <= 1'b0;
    end else if (cmd.start) begin
      issue_r <= 1'b1;
      rd_v_r  <= 1'b0;
      addr_r  <= '0;
    end else begin
      rd_v_r <= issue_r;
      if (issue_r) begin
        rd_idx_r   <= addr_r;
        rd_valid_r <= valid_r[addr_r];
        if (addr_r == LAST_IDX) begin
          issue_r <= 1'b0;
        end else begin
          addr_r <= addr_r + 1'b1;
        end
      end
    end
  end

  // Entry memory: registered read during the scan, one write at the commit of a bind or clear.
  always_ff @(posedge clk) begin
    if (issue_r) begin
      rd_q_r <= mem[addr_r];
    end
    if (write_en) begin
      mem[wslot] <= '{key: key_r, stamp: frame_r, binds: binds_nxt, clears: clears_nxt};
    end
  end

  // Comparisons on the entry read in the previous cycle.
  always_comb begin
    live       = rd_v_r && rd_valid_r;
    key_eq     = rd_q_r.key == key_r;
    sel_eq     = rd_q_r.key == sel_r;
    lru_better = !lru_any_r || (rd_q_r.stamp < lru_stamp_r) ||
                 ((rd_q_r.stamp == lru_stamp_r) && (rd_q_r.key < lru_key_r));
  end

  // Trackers: first match of the key, first free slot, oldest entry and
  // the stamp of the selected key.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
      lru_any_r <= 1'b0;
      selhit_r  <= 1'b0;
    end else if (rd_v_r) begin
      if (live && key_eq && !hit_r) begin
        hit_r        <= 1'b1;
        hit_slot_r   <= rd_idx_r;
        hit_binds_r  <= rd_q_r.binds;
        hit_clears_r <= rd_q_r.clears;
      end
      if (!rd_valid_r && !free_r) begin
        free_r      <= 1'b1;
        free_slot_r <= rd_idx_r;
      end
      if (live && lru_better) begin
        lru_any_r   <= 1'b1;
        lru_slot_r  <= rd_idx_r;
        lru_key_r   <= rd_q_r.key;
        lru_stamp_r <= rd_q_r.stamp;
      end
      if (live && sel_eq && !selhit_r) begin
        selhit_r    <= 1'b1;
        sel_stamp_r <= rd_q_r.stamp;
      end
    end
  end

  // Commit decision: hit, insert into a free slot, or evict the oldest.
  always_comb begin
    is_event    = ((op_r == OP_BIND) || (op_r == OP_CLEAR)) && (key_r != '0);
    wslot       = hit_slot_r;
    binds0      = hit_binds_r;
    clears0     = hit_clears_r;
    status_nxt  = ST_NONE;
    evicted_nxt = '0;
    dropped_nxt = 1'b0;
    sel_nxt     = sel_r;
    version_nxt = version_r;
    count_nxt   = count_r;
    if (is_event && !hit_r) begin
      binds0      = '0;
      clears0     = '0;
      version_nxt = version_r + 1'b1;
      if (free_r) begin
        wslot      = free_slot_r;
        status_nxt = ST_INSERT;
        count_nxt  = count_r + 1'b1;
      end else begin
        wslot       = lru_slot_r;
        status_nxt  = ST_EVICT;
        evicted_nxt = lru_key_r;
        if (lru_key_r == sel_r) begin
          dropped_nxt = 1'b1;
          sel_nxt     = '0;
        end
      end
    end else if (is_event) begin
      status_nxt = ST_HIT;
    end else if (op_r == OP_SELECT && key_r != '0 && hit_r) begin
      status_nxt = ST_HIT;
    end
    binds_nxt  = (op_r == OP_BIND) ? sat_inc(binds0) : binds0;
    clears_nxt = (op_r == OP_CLEAR) ? sat_inc(clears0) : clears0;
  end

  // Freshness of the selected key after this item.
  always_comb begin
    if (is_event && sel_nxt == key_r) begin
      fresh_found = 1'b1;
      fresh_stamp = frame_r;
    end else begin
      fresh_found = selhit_r;
      fresh_stamp = sel_stamp_r;
    end
    age       = frame_r - fresh_stamp;
    fresh_nxt = (sel_nxt != '0) && fresh_found &&
                (age < STAMP_W'(stale_r));
  end

  // Result assembly.
  always_comb begin
    write_en   = cmd.commit && is_event;
    slot_wide  = (IDX_W + SLOT_W)'(wslot);
    count_wide = (CNT_W + NUM_W)'(count_nxt);
    res_nxt.status           = status_nxt;
    res_nxt.slot             = (status_nxt == ST_NONE) ? '0 : slot_wide[SLOT_W-1:0];
    res_nxt.evicted_key      = evicted_nxt;
    res_nxt.selected_dropped = dropped_nxt;
    res_nxt.bind_count       = (status_nxt == ST_NONE) ? '0 :
                               (is_event ? binds_nxt : hit_binds_r);
    res_nxt.clear_count      = (status_nxt == ST_NONE) ? '0 :
                               (is_event ? clears_nxt : hit_clears_r);
    res_nxt.version          = version_nxt;
    res_nxt.entry_count      = count_wide[NUM_W-1:0];
    res_nxt.selected_fresh   = fresh_nxt;
  end

  // Table bookkeeping at commit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      version_r <= '0;
      count_r   <= '0;
    end else if (cmd.commit) begin
      version_r <= version_nxt;
      count_r   <= count_nxt;
      if (is_event) begin
        valid_r[wslot] <= 1'b1;
      end
    end
  end

  // Result register: holds a result until its transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_r <= res_nxt;
    end
  end

  assign res            = res_r;
  assign res_valid      = res_valid_r;
  assign stat.scan_done = rd_v_r && (rd_idx_r == LAST_IDX);
  assign stat.out_free  = !res_valid_r || res_ready;

endmodule

`default_nettype wire

>>> rtl/lct_ctrl.sv
// ----------------------------------------------------------------------------
// lct_ctrl
// Sequencer for one item: capture, table scan, commit of the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lct_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lct_pkg::lct_stat_t stat,
  output lct_pkg::lct_cmd_t  cmd
);
  import lct_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lru_candidate_table.sv
// ----------------------------------------------------------------------------
// lru_candidate_table
// Fully associative keyed table with oldest-stamp eviction and freshness.
// ----------------------------------------------------------------------------
//   Channel  Direction  Contents
//   in_ch    in         operation, key
//   out_ch   out        status, slot, evicted_key, counters, version, fresh
//   cfg_*    in         staleness threshold write (cfg_we, cfg_wdata)
//
// An item is held through the scan of the entry memory, which goes through
// its single read port, one entry per cycle, and through the commit; only
// then can the next item be taken.
// The result appears in the cycle after the commit; a new item may be taken
// while a result still waits. A stalled result holds only the commit step.
// Reset is synchronous and leaves the table empty with no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_candidate_table #(
  parameter int ENTRIES = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  lct_in_if.sink                     in_ch,
  lct_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [lct_pkg::STALE_W-1:0] cfg_wdata
);
  import lct_pkg::*;

  `include "assert_macros.svh"

  lct_cmd_t  cmd;
  lct_stat_t stat;
  lct_res_t  res;
  logic      res_valid;

  // Controller.
  lct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  lct_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_operation (in_ch.operation),
    .in_key       (in_ch.key),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .res          (res),
    .res_valid    (res_valid),
    .res_ready    (out_ch.ready)
  );

  // Result channel.
  assign out_ch.valid            = res_valid;
  assign out_ch.status           = res.status;
  assign out_ch.slot             = res.slot;
  assign out_ch.evicted_key      = res.evicted_key;
  assign out_ch.selected_dropped = res.selected_dropped;
  assign out_ch.bind_count       = res.bind_count;
  assign out_ch.clear_count      = res.clear_count;
  assign out_ch.version          = res.version;
  assign out_ch.entry_count      = res.entry_count;
  assign out_ch.selected_fresh   = res.selected_fresh;

  // Checks.
  `LCT_ASSERT_NEXT(a_busy_after_take, in_ch.valid && in_ch.ready, !in_ch.ready,
    "input taken while an item is still in progress")
  `LCT_ASSERT_NEXT(a_commit_shows, cmd.commit, out_ch.valid,
    "commit did not present a result")
  `LCT_ASSERT_SAME(a_evict_full, out_ch.valid && out_ch.status == ST_EVICT,
    out_ch.entry_count == NUM_W'(ENTRIES), "eviction from a table that is not full")
  `LCT_ASSERT_SAME(a_drop_evict, out_ch.valid && out_ch.selected_dropped,
    out_ch.status == ST_EVICT && !out_ch.selected_fresh,
    "selection dropped without an eviction")

endmodule

`default_nettype wire

>>> verif/tb_lru_candidate_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_candidate_table
// Self-checking bench for the keyed candidate table. A shadow copy of the
// table predicts each result from the accepted events: lookups, inserts,
// oldest-stamp eviction with the smallest key winning ties, saturating
// counters, the wrapping version and selected-key freshness. Both channels
// idle at random outside the steady-flow phase, and the staleness threshold
// is changed between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb_lru_candidate_table;
  import lct_pkg::*;

  localparam int ENTRIES     = 24;
  localparam int POOL_SIZE   = 36;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 105;
  localparam int STALL_LIMIT = 2000;

  // Shadow of the table: predicts one result per accepted event and checks
  // the results in order of arrival.
  class candidate_table_shadow;
    bit                 slot_used[ENTRIES];
    bit [KEY_W-1:0]     slot_key[ENTRIES];
    bit [STAMP_W-1:0]   slot_stamp[ENTRIES];
    bit [CTR_W-1:0]     slot_binds[ENTRIES];
    bit [CTR_W-1:0]     slot_clears[ENTRIES];
    bit [STAMP_W-1:0]   frame_no;
    bit [KEY_W-1:0]     chosen_key;
    bit [CTR_W-1:0]     insert_ver;
    bit [STALE_W-1:0]   stale_limit;
    lct_res_t           awaited[$];
    int                 mismatches;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      frame_no    = '0;
      chosen_key  = '0;
      insert_ver  = '0;
      stale_limit = STALE_RESET;
      mismatches  = 0;
    endfunction

    function void set_stale(bit [STALE_W-1:0] value);
      stale_limit = value;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function int find_slot(bit [KEY_W-1:0] key);
      foreach (slot_used[i])
        if (slot_used[i] && slot_key[i] == key) return i;
      return -1;
    endfunction

    function bit [CTR_W-1:0] bump(bit [CTR_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    // Applies one accepted event to the shadow and queues its result.
    function void note_event(bit [OP_W-1:0] op, bit [KEY_W-1:0] key);
      lct_res_t r;
      int s;
      int count;
      r = '0;
      case (op)
        OP_TICK: begin
          frame_no++;
        end
        OP_SELECT: begin
          chosen_key = key;
          s = find_slot(key);
          if (key != '0 && s >= 0) begin
            r.status      = ST_HIT;
            r.slot        = SLOT_W'(s);
            r.bind_count  = slot_binds[s];
            r.clear_count = slot_clears[s];
          end
        end
        OP_BIND, OP_CLEAR: begin
          if (key != '0) begin
            s = find_slot(key);
            if (s >= 0) begin
              r.status = ST_HIT;
            end else begin
              // Lowest free slot first; a full table gives up its oldest entry.
              for (int i = ENTRIES - 1; i >= 0; i--)
                if (!slot_used[i]) s = i;
              r.status = ST_INSERT;
              if (s < 0) begin
                s = 0;
                for (int i = 1; i < ENTRIES; i++)
                  if (slot_stamp[i] < slot_stamp[s] ||
                      (slot_stamp[i] == slot_stamp[s] && slot_key[i] < slot_key[s]))
                    s = i;
                r.evicted_key = slot_key[s];
                if (slot_key[s] == chosen_key) begin
                  chosen_key         = '0;
                  r.selected_dropped = 1'b1;
                end
                r.status = ST_EVICT;
              end
              slot_used[s]   = 1'b1;
              slot_key[s]    = key;
              slot_binds[s]  = '0;
              slot_clears[s] = '0;
              insert_ver++;
            end
            slot_stamp[s] = frame_no;
            if (op == OP_CLEAR) slot_clears[s] = bump(slot_clears[s]);
            else slot_binds[s] = bump(slot_binds[s]);
            r.slot        = SLOT_W'(s);
            r.bind_count  = slot_binds[s];
            r.clear_count = slot_clears[s];
          end
        end
        default: ;
      endcase

      // Freshness of the selected key, and the occupancy after the event.
      if (chosen_key != '0) begin
        s = find_slot(chosen_key);
        if (s >= 0)
          r.selected_fresh = (STAMP_W'(frame_no - slot_stamp[s]) < STAMP_W'(stale_limit));
      end
      count = 0;
      foreach (slot_used[i]) if (slot_used[i]) count++;
      r.version     = insert_ver;
      r.entry_count = NUM_W'(count);
      awaited = {awaited, r};
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Compares one result transfer with the oldest prediction.
    function void check_result(lct_res_t got);
      lct_res_t want;
      if (awaited.size() == 0) begin
        $error("result transfer with no event awaiting a result");
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("slot", 64'(want.slot), 64'(got.slot));
      compare_field("evicted_key", want.evicted_key, got.evicted_key);
      compare_field("selected_dropped", 64'(want.selected_dropped),
                    64'(got.selected_dropped));
      compare_field("bind_count", 64'(want.bind_count), 64'(got.bind_count));
      compare_field("clear_count", 64'(want.clear_count), 64'(got.clear_count));
      compare_field("version", 64'(want.version), 64'(got.version));
      compare_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
      compare_field("selected_fresh", 64'(want.selected_fresh),
                    64'(got.selected_fresh));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [STALE_W-1:0] cfg_wdata;
  bit                 steady_flow = 1'b0;
  int                 sink_stall = 0;
  logic [KEY_W-1:0]   key_pool[POOL_SIZE];

  candidate_table_shadow table_shadow;

  lct_in_if  in_ch();
  lct_out_if out_ch();

  lru_candidate_table #(.ENTRIES(ENTRIES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Keys lean on a small pool so that hits and evictions are frequent.
  function automatic logic [KEY_W-1:0] draw_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 15) return {$urandom, $urandom};
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Result side: ready drops for random stretches unless the flow is steady.
  always @(posedge clk) begin
    if (sink_stall != 0) begin
      out_ch.ready <= 1'b0;
      sink_stall   <= sink_stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!steady_flow && $urandom_range(0, 5) == 0) sink_stall <= pick_gap();
    end
  end

  // Every result transfer is checked against the shadow.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      table_shadow.check_result('{
        status:           out_ch.status,
        slot:             out_ch.slot,
        evicted_key:      out_ch.evicted_key,
        selected_dropped: out_ch.selected_dropped,
        bind_count:       out_ch.bind_count,
        clear_count:      out_ch.clear_count,
        version:          out_ch.version,
        entry_count:      out_ch.entry_count,
        selected_fresh:   out_ch.selected_fresh
      });
    end
  end

  // Offers one event after a random gap and waits for its transfer.
  task automatic send_event(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    int gap;
    gap = steady_flow ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.key       <= key;
    do @(posedge clk); while (!in_ch.ready);
    table_shadow.note_event(op, key);
  endtask

  // Waits until every result has arrived and the block has gone quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (table_shadow.pending() != 0) @(posedge clk);
    repeat (ENTRIES + 3) @(posedge clk);
  endtask

  task automatic write_stale(input logic [STALE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    table_shadow.set_stale(value);
  endtask

  // Fills the table with new keys in one frame, selects the smallest and
  // forces one more insert, so the tie goes to the selected key and drops it.
  task automatic flood_and_drop();
    logic [KEY_W-1:0] flood_keys[ENTRIES];
    logic [KEY_W-1:0] least;
    send_event(OP_TICK, {$urandom, $urandom});
    foreach (flood_keys[i]) begin
      flood_keys[i] = {$urandom, $urandom} | 64'd1;
      send_event(($urandom_range(0, 1) == 0) ? OP_BIND : OP_CLEAR, flood_keys[i]);
    end
    least = flood_keys[0];
    foreach (flood_keys[i]) if (flood_keys[i] < least) least = flood_keys[i];
    send_event(OP_SELECT, least);
    send_event(OP_BIND, {$urandom, $urandom} | 64'd1);
  endtask

  // Random event mix with one flood sequence per phase.
  task automatic random_phase();
    int flood_at;
    int r;
    logic [OP_W-1:0] op;
    flood_at = $urandom_range(0, PHASE_ITEMS - 1);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n == flood_at) flood_and_drop();
      r  = $urandom_range(0, 99);
      op = (r < 15) ? OP_TICK : (r < 50) ? OP_BIND : (r < 80) ? OP_CLEAR : OP_SELECT;
      send_event(op, (op == OP_TICK) ? {$urandom, $urandom} : draw_key());
    end
  endtask

  initial begin : stimulus
    logic [STALE_W-1:0] stale_value;
    table_shadow    = new();
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_TICK;
    in_ch.key       = '0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    foreach (key_pool[i])
      key_pool[i] = (i % 2 == 0) ? KEY_W'($urandom_range(1, 64)) : {$urandom, $urandom} | 64'd1;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed events at the threshold left by reset: ignored keys, absent
    // and present selections, insert, hit and clearing the selection.
    send_event(OP_TICK, '1);
    send_event(OP_BIND, '0);
    send_event(OP_CLEAR, '0);
    send_event(OP_SELECT, '1);
    send_event(OP_BIND, '1);
    send_event(OP_CLEAR, '1);
    send_event(OP_BIND, 64'd1);
    send_event(OP_SELECT, 64'd1);
    send_event(OP_TICK, '0);
    send_event(OP_SELECT, 64'h8000_0000_0000_0000);
    send_event(OP_SELECT, '0);
    send_event(OP_CLEAR, 64'h5555_5555_5555_5555);
    settle();

    // Each phase runs at its own threshold, extremes and zero among them.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       stale_value = 20'd1;
        1:       stale_value = 20'd0;
        2:       stale_value = 20'd1000000;
        3:       stale_value = 20'd3;
        4:       stale_value = STALE_W'($urandom_range(2, 40));
        default: stale_value = STALE_W'($urandom_range(1, 1000000));
      endcase
      write_stale(stale_value);
      steady_flow = (phase == 3);
      random_phase();
      settle();
    end

    if (table_shadow.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Ends the run when neither channel has moved for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/lct_pkg.sv
rtl/lct_in_if.sv
rtl/lct_out_if.sv
rtl/lct_datapath.sv
rtl/lct_ctrl.sv
rtl/lru_candidate_table.sv
verif/tb_lru_candidate_table.sv
